### rtl/irspe_pkg.sv
// Package for the IR shot packet encoder: field widths, codes, register
// indexes, reset values and the damage quantizer.
// No dependencies; used by rtl/ir_shot_packet_encoder.sv.
`default_nettype none

package irspe_pkg;

  // Field widths
  localparam int PLAYER_W = 7;
  localparam int TEAM_W   = 2;
  localparam int DUR_W    = 15;
  localparam int DAMAGE_W = 8;
  localparam int CH_W     = 2;
  localparam int CODE_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 3;

  // Frame layout and symbol count
  localparam int FRAME_BYTES  = 4;
  localparam int MAX_SYMBOLS  = 64;
  localparam int RESULT_LIMIT = 33;
  localparam int TOTAL_RAW    = 1 + 8 * FRAME_BYTES;
  localparam int TOTAL_CAP1   = (TOTAL_RAW > MAX_SYMBOLS) ? MAX_SYMBOLS : TOTAL_RAW;
  localparam int TOTAL_SYMS   = (TOTAL_CAP1 > RESULT_LIMIT) ? RESULT_LIMIT : TOTAL_CAP1;
  localparam int DATA_BITS    = TOTAL_SYMS - 1;
  localparam int SYM_CNT_W    = $clog2(DATA_BITS + 1);
  // Only bytes 0 and 1 of the frame carry nonzero bits.
  localparam int HOT_BITS     = 16;

  localparam int NUM_CHANNELS = 4;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_SENT     = 2'd0,
    ST_BUSY     = 2'd1,
    ST_DISABLED = 2'd2
  } status_t;

  // Input kinds
  typedef enum logic {
    KIND_FIRE = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYER   = 3'd0,
    REG_TEAM     = 3'd1,
    REG_HEADER   = 3'd2,
    REG_ONE      = 3'd3,
    REG_ZERO     = 3'd4,
    REG_SPACE    = 3'd5,
    REG_TX_EN    = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [PLAYER_W-1:0] PLAYER_RST = 7'd1;
  localparam logic [TEAM_W-1:0]   TEAM_RST   = 2'd0;
  localparam logic [DUR_W-1:0]    HEADER_RST = 15'd2400;
  localparam logic [DUR_W-1:0]    ONE_RST    = 15'd1200;
  localparam logic [DUR_W-1:0]    ZERO_RST   = 15'd600;
  localparam logic [DUR_W-1:0]    SPACE_RST  = 15'd600;

  // Sixteen-range damage quantizer; anything over 100 codes as zero.
  function automatic logic [CODE_W-1:0] damage_code(input logic [DAMAGE_W-1:0] d);
    logic [CODE_W-1:0] c;
    if (d <= 8'd1)        c = 4'd0;
    else if (d <= 8'd3)   c = 4'd1;
    else if (d == 8'd4)   c = 4'd2;
    else if (d <= 8'd6)   c = 4'd3;
    else if (d <= 8'd9)   c = 4'd4;
    else if (d <= 8'd14)  c = 4'd5;
    else if (d <= 8'd16)  c = 4'd6;
    else if (d <= 8'd19)  c = 4'd7;
    else if (d <= 8'd24)  c = 4'd8;
    else if (d <= 8'd29)  c = 4'd9;
    else if (d <= 8'd34)  c = 4'd10;
    else if (d <= 8'd39)  c = 4'd11;
    else if (d <= 8'd49)  c = 4'd12;
    else if (d <= 8'd74)  c = 4'd13;
    else if (d <= 8'd99)  c = 4'd14;
    else if (d == 8'd100) c = 4'd15;
    else                  c = 4'd0;
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/ir_shot_packet_encoder.sv
// IR shot packet encoder top level: input register, symbol emitter with
// output register, per-channel busy flags and configuration registers.
// Depends on rtl/irspe_pkg.sv.
// Usage:
//   Input beats (s_*) carry a fire request or a done event (s_tuser = kind).
//   A fire on an enabled, idle channel produces 33 output beats: a header
//   symbol and 32 data symbols, MSB of byte 0 first, tlast on the final one.
//   A fire on a busy channel, or while transmitters are disabled or on a
//   channel that does not exist, produces one status beat with tlast set.
//   A done event frees its channel and produces no output beat.
//   With the emitter free, a fire goes from the input register to the output
//   register, which presents its first beat. Throughput: one output beat per
//   cycle while m_tready is high; no new item enters the emitter before the
//   last symbol of a frame. The input register takes the next item while the
//   current frame is still going out. Reset clears all busy flags, empties
//   both registers and loads the configuration defaults (transmitters
//   disabled). When the receiver holds m_tready low the output beat holds and
//   the emitter stops; the input side stalls once its register is full.
//   The user must see that configuration is written through
//   cfg_we/cfg_index/cfg_data only while idle; the block itself has no check.
`default_nettype none

module ir_shot_packet_encoder #(
  parameter int NUM_CHANNELS = irspe_pkg::NUM_CHANNELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] damage, [9:8] channel, [15:10] zero
  input  wire logic        s_tuser,   // [0] kind
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [1:0] tx_channel, [16:2] mark_us, [31:17] gap_us
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic             m_tlast,   // last
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [irspe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [irspe_pkg::DUR_W-1:0]     cfg_data
);

  localparam int CH_W  = irspe_pkg::CH_W;
  localparam int DUR_W = irspe_pkg::DUR_W;
  localparam int CNT_W = irspe_pkg::SYM_CNT_W;
  localparam int HOT_W = irspe_pkg::HOT_BITS;

  // Configuration registers
  logic [irspe_pkg::PLAYER_W-1:0] player_number;
  logic [irspe_pkg::TEAM_W-1:0]   team_number;
  logic [DUR_W-1:0]               header_on_us;
  logic [DUR_W-1:0]               one_on_us;
  logic [DUR_W-1:0]               zero_on_us;
  logic [DUR_W-1:0]               space_us;
  logic                           tx_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_number <= irspe_pkg::PLAYER_RST;
      team_number   <= irspe_pkg::TEAM_RST;
      header_on_us  <= irspe_pkg::HEADER_RST;
      one_on_us     <= irspe_pkg::ONE_RST;
      zero_on_us    <= irspe_pkg::ZERO_RST;
      space_us      <= irspe_pkg::SPACE_RST;
      tx_enabled    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        irspe_pkg::REG_PLAYER: player_number <= cfg_data[irspe_pkg::PLAYER_W-1:0];
        irspe_pkg::REG_TEAM:   team_number   <= cfg_data[irspe_pkg::TEAM_W-1:0];
        irspe_pkg::REG_HEADER: header_on_us  <= cfg_data;
        irspe_pkg::REG_ONE:    one_on_us     <= cfg_data;
        irspe_pkg::REG_ZERO:   zero_on_us    <= cfg_data;
        irspe_pkg::REG_SPACE:  space_us      <= cfg_data;
        irspe_pkg::REG_TX_EN:  tx_enabled    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                            in_valid;
  logic                            in_kind;
  logic [irspe_pkg::DAMAGE_W-1:0]  in_damage;
  logic [CH_W-1:0]                 in_ch;

  // Emitter and output register
  logic                   out_valid;
  irspe_pkg::status_t     out_status;
  logic [CH_W-1:0]        out_ch;
  logic [DUR_W-1:0]       out_mark;
  logic [DUR_W-1:0]       out_gap;
  logic                   out_last;
  logic [HOT_W-1:0]       frame;
  logic [CNT_W-1:0]       remaining;
  logic [NUM_CHANNELS-1:0] busy;

  logic advance;
  logic take;
  logic in_fire;
  logic ch_valid;
  logic busy_hit;
  logic load_frame;
  logic [NUM_CHANNELS-1:0] ch_sel;

  assign advance  = !out_valid || m_tready;
  assign take     = advance && (remaining == '0) && in_valid;
  assign s_tready = !in_valid || take;

  // Decode the pending item's channel against the channel count.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_sel[i] = (32'(in_ch) == i);
    end
  end

  assign ch_valid   = |ch_sel;
  assign busy_hit   = |(busy & ch_sel);
  assign in_fire    = (in_kind == irspe_pkg::KIND_FIRE);
  assign load_frame = take && in_fire && tx_enabled && ch_valid && !busy_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind   <= s_tuser;
      in_damage <= s_tdata[7:0];
      in_ch     <= s_tdata[9:8];
    end
  end

  // Busy flags: set when a frame starts, cleared by a done event.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (take) begin
      if (!in_fire) begin
        busy <= busy & ~ch_sel;
      end else if (load_frame) begin
        busy <= busy | ch_sel;
      end
    end
  end

  // Emitter control: continue the current frame, else start on the pending item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remaining <= '0;
    end else if (advance) begin
      if (remaining != '0) begin
        out_valid <= 1'b1;
        remaining <= remaining - 1'b1;
      end else if (take) begin
        out_valid <= in_fire;
        remaining <= load_frame ? CNT_W'(irspe_pkg::DATA_BITS) : '0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Emitter payload
  always_ff @(posedge clk) begin
    if (advance) begin
      if (remaining != '0) begin
        out_status <= irspe_pkg::ST_SENT;
        out_mark   <= frame[HOT_W-1] ? one_on_us : zero_on_us;
        out_gap    <= space_us;
        out_last   <= (remaining == CNT_W'(1));
        frame      <= {frame[HOT_W-2:0], 1'b0};
      end else if (take) begin
        out_ch <= in_ch;
        if (load_frame) begin
          out_status <= irspe_pkg::ST_SENT;
          out_mark   <= header_on_us;
          out_gap    <= space_us;
          out_last   <= (irspe_pkg::DATA_BITS == 0);
          frame      <= {1'b0, player_number, team_number,
                         irspe_pkg::damage_code(in_damage), 2'b00};
        end else begin
          out_status <= (!tx_enabled || !ch_valid) ? irspe_pkg::ST_DISABLED
                                                   : irspe_pkg::ST_BUSY;
          out_mark   <= '0;
          out_gap    <= '0;
          out_last   <= 1'b1;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_gap, out_mark, out_ch};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

`ifndef NO_ASSERTIONS
  // A status beat is always the only and final beat of its item.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != irspe_pkg::ST_SENT) |-> m_tlast)
    else $error("status beat without tlast");

  // While frame symbols remain, the current beat is a non-final symbol.
  a_frame_open: assert property (@(posedge clk) disable iff (rst)
    (remaining != '0) |-> (m_tvalid && m_tuser == irspe_pkg::ST_SENT && !m_tlast))
    else $error("frame symbols pending behind a final or missing beat");

  // Starting a frame marks its channel busy.
  a_busy_set: assert property (@(posedge clk) disable iff (rst)
    load_frame |=> ((busy & $past(ch_sel)) != '0))
    else $error("channel not busy after frame start");

  // The input side stalls only behind a full input register.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid)
    else $error("input stalled with empty register");
`endif

endmodule

`default_nettype wire
